// ----- sv/mcm_pkg.sv -----
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types, register codes and the sine table entry function for the
// metronome click mixer.
// ----------------------------------------------------------------------------
package mcm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int ROM_BITS    = 15;
    localparam int VOL_BITS    = 16;
    localparam int CNT_BITS    = 24;
    localparam int CLK_BITS    = 16;
    localparam int STEP_BITS   = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLES_PER_BEAT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLICK_LENGTH      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VOLUME            = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACCENT_PHASE_STEP = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_PHASE_STEP = 3'd4;

    localparam logic [CNT_BITS-1:0]  RST_SAMPLES_PER_BEAT  = 24'd24000;
    localparam logic [CLK_BITS-1:0]  RST_CLICK_LENGTH      = 16'd960;
    localparam logic [VOL_BITS-1:0]  RST_VOLUME            = 16'd32768;
    localparam logic [STEP_BITS-1:0] RST_ACCENT_PHASE_STEP = 32'd107374182;
    localparam logic [STEP_BITS-1:0] RST_NORMAL_PHASE_STEP = 32'd71582788;

    localparam longint Q30_ONE = 64'sd1073741824;

    // one input word
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_left;
        logic signed [SAMPLE_BITS-1:0] in_right;
        logic                          restart;
        logic                          block_end;
    } frame_t;

    // one result word
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic                          beat_start;
        logic                          accent;
        logic                          click_active;
        logic                          block_end_out;
    } mix_t;

    // frame in flight between the beat stage and the mix stage
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          negate;
        logic                          active;
        logic                          beat_start;
        logic                          accent;
        logic                          block_end;
    } mcm_item_t;

    // Quarter-wave entry: Q30 odd polynomial at the bin midpoint, scaled to Q15.
    function automatic logic [ROM_BITS-1:0] sine_entry(input int addr_bits, input int idx);
        longint x;
        longint x2;
        longint p;
        longint s;
        x  = (2 * longint'(idx) + 64'sd1) << (29 - addr_bits);
        x2 = (x * x) / Q30_ONE;
        p  = 64'sd172272;
        p  = -64'sd5026995 + (p * x2) / Q30_ONE;
        p  = 64'sd85569306 + (p * x2) / Q30_ONE;
        p  = -64'sd693598668 + (p * x2) / Q30_ONE;
        p  = 64'sd1686629713 + (p * x2) / Q30_ONE;
        s  = (p * x) / Q30_ONE;
        if (s < 0)
            s = 0;
        s = (s * 64'sd32767 + (64'sd1 << 29)) / Q30_ONE;
        if (s > 64'sd32767)
            s = 64'sd32767;
        return s[ROM_BITS-1:0];
    endfunction

endpackage

// ----- sv/mcm_sine_rom.sv -----
// ----------------------------------------------------------------------------
// mcm_sine_rom
// Quarter-wave sine table with a registered read port.
// ----------------------------------------------------------------------------
module mcm_sine_rom
    import mcm_pkg::*;
#(
    parameter int ADDR_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] addr,
    output logic [ROM_BITS-1:0]  data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    typedef logic [ROM_BITS-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < DEPTH; i++)
        begin
            r[i] = sine_entry(ADDR_BITS, i);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [ROM_BITS-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

// ----- sv/mcm_beat.sv -----
// ----------------------------------------------------------------------------
// mcm_beat
// Configuration registers, beat countdown, click counter, beat count and
// phase accumulator; registers the frame for the mix stage.
// ----------------------------------------------------------------------------
module mcm_beat
    import mcm_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      take,
    input  frame_t                    frame,
    output logic [SINE_ADDR_BITS-1:0] rom_addr,
    output logic [VOL_BITS-1:0]       volume,
    output mcm_item_t                 item
);

    logic [CNT_BITS-1:0]   spb_reg;
    logic [CLK_BITS-1:0]   clen_reg;
    logic [VOL_BITS-1:0]   vol_reg;
    logic [STEP_BITS-1:0]  acc_step_reg;
    logic [STEP_BITS-1:0]  nrm_step_reg;

    logic [CNT_BITS-1:0]   countdown_reg;
    logic [CNT_BITS-1:0]   countdown_next;
    logic [CLK_BITS-1:0]   click_left_reg;
    logic [CLK_BITS-1:0]   click_left_next;
    logic [1:0]            beat_count_reg;
    logic [1:0]            beat_count_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    mcm_item_t             item_reg;
    mcm_item_t             item_next;

    logic [CLK_BITS-1:0]   click_cur;
    logic [1:0]            beat_cur;
    logic [PHASE_BITS-1:0] phase_cur;
    logic                  start;
    logic                  accent;
    logic                  active;
    logic [1:0]            quad;
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [STEP_BITS-1:0]  step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg      <= RST_SAMPLES_PER_BEAT;
            clen_reg     <= RST_CLICK_LENGTH;
            vol_reg      <= RST_VOLUME;
            acc_step_reg <= RST_ACCENT_PHASE_STEP;
            nrm_step_reg <= RST_NORMAL_PHASE_STEP;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_SAMPLES_PER_BEAT:  spb_reg      <= cfg_data[CNT_BITS-1:0];
                REG_CLICK_LENGTH:      clen_reg     <= cfg_data[CLK_BITS-1:0];
                REG_VOLUME:            vol_reg      <= cfg_data[VOL_BITS-1:0];
                REG_ACCENT_PHASE_STEP: acc_step_reg <= cfg_data[STEP_BITS-1:0];
                REG_NORMAL_PHASE_STEP: nrm_step_reg <= cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        // restart clears click counter, beat count and phase before the beat check
        click_cur = frame.restart ? '0 : click_left_reg;
        beat_cur  = frame.restart ? '0 : beat_count_reg;
        phase_cur = frame.restart ? '0 : phase_reg;

        start = (countdown_reg == '0);
        if (start)
        begin
            click_cur = clen_reg;
            beat_cur  = beat_cur + 2'd1;
        end
        countdown_next = (start ? spb_reg : countdown_reg) - CNT_BITS'(1);

        accent = (beat_cur == 2'd1);
        active = (click_cur != '0);

        quad = phase_cur[PHASE_BITS-1 -: 2];
        idx  = phase_cur[PHASE_BITS-3 -: SINE_ADDR_BITS];
        if (quad[0])
        begin
            idx = ~idx;
        end

        step            = accent ? acc_step_reg : nrm_step_reg;
        phase_next      = active ? phase_cur + step[PHASE_BITS-1:0] : phase_cur;
        click_left_next = active ? click_cur - CLK_BITS'(1) : click_cur;
        beat_count_next = beat_cur;

        item_next.left       = frame.in_left;
        item_next.right      = frame.in_right;
        item_next.negate     = quad[1];
        item_next.active     = active;
        item_next.beat_start = start;
        item_next.accent     = accent;
        item_next.block_end  = frame.block_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg  <= '0;
            click_left_reg <= '0;
            beat_count_reg <= '0;
            phase_reg      <= '0;
        end
        else if (take)
        begin
            countdown_reg  <= countdown_next;
            click_left_reg <= click_left_next;
            beat_count_reg <= beat_count_next;
            phase_reg      <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign rom_addr = idx;
    assign volume   = vol_reg;
    assign item     = item_reg;

    a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        take && !frame.restart && !start |=> beat_count_reg == $past(beat_count_reg))
        else $error("beat count moved without a beat start or restart");

    a_click_load: assert property (@(posedge clk) disable iff (!rst_n)
        take && start && (clen_reg != '0)
        |=> click_left_reg == $past(clen_reg) - CLK_BITS'(1))
        else $error("click counter not loaded at beat start");

endmodule

// ----- sv/mcm_mix.sv -----
// ----------------------------------------------------------------------------
// mcm_mix
// Volume scaling of the sine entry, saturating mix into both channels and
// the result register.
// ----------------------------------------------------------------------------
module mcm_mix
    import mcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  mcm_item_t           item,
    input  logic [ROM_BITS-1:0] rom_data,
    input  logic [VOL_BITS-1:0] volume,
    input  logic                mix_stall,
    output logic                busy,
    output logic                mix_valid,
    output mix_t                mix
);

    localparam int PROD_BITS = ROM_BITS + VOL_BITS;
    localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

    logic                 s1_vld_reg;
    logic                 s1_vld_next;
    logic                 out_vld_reg;
    mix_t                 out_reg;
    mix_t                 out_next;
    logic                 advance;

    logic [PROD_BITS-1:0] prod;
    logic [PROD_BITS-1:0] rounded;
    logic [VOL_BITS-1:0]  mag;
    logic signed [SUM_BITS-1:0] click;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_add(
        input logic signed [SAMPLE_BITS-1:0] s,
        input logic signed [SUM_BITS-1:0]    c
    );
        logic signed [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(s) + c;
        if (sum > SAT_HI)
            sum = SAT_HI;
        else if (sum < SAT_LO)
            sum = SAT_LO;
        return sum[SAMPLE_BITS-1:0];
    endfunction

    assign advance     = !out_vld_reg || !mix_stall;
    assign busy        = s1_vld_reg && !advance;
    assign s1_vld_next = take ? 1'b1 : (advance ? 1'b0 : s1_vld_reg);

    always_comb
    begin
        prod    = PROD_BITS'(rom_data) * PROD_BITS'(volume);
        rounded = prod + PROD_BITS'(16384);
        mag     = rounded[PROD_BITS-1 -: VOL_BITS];
        click   = '0;
        if (item.active)
        begin
            click = item.negate ? -$signed(SUM_BITS'(mag)) : $signed(SUM_BITS'(mag));
        end
        out_next.out_left      = sat_add(item.left, click);
        out_next.out_right     = sat_add(item.right, click);
        out_next.beat_start    = item.beat_start;
        out_next.accent        = item.accent;
        out_next.click_active  = item.active;
        out_next.block_end_out = item.block_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            if (advance)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_vld_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign mix_valid = out_vld_reg;
    assign mix       = out_reg;

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> s1_vld_reg)
        else $error("accepted word did not reach the mix stage");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(take && busy))
        else $error("word accepted while the mix stage is blocked");

    a_quiet_pass: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_vld_reg && !item.active
        |=> out_reg.out_left == $past(item.left) && out_reg.out_right == $past(item.right))
        else $error("samples changed on a frame without click");

endmodule

// ----- sv/metronome_click_mixer_top.sv -----
// ----------------------------------------------------------------------------
// metronome_click_mixer_top
// Adds a metronome click (sine tone bursts, accent on every fourth beat) to a
// stereo sample stream with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   frame channel (frame_valid / frame_stall / frame): one stereo frame per
//   word, with a restart mark that clears beat count, click counter and
//   phase before that frame, and a block end mark that is passed through.
//   mix channel (mix_valid / mix_stall / mix): one result word per frame,
//   in order, with beat start, accent and click activity flags.
//   cfg port (cfg_wen / cfg_index / cfg_data): single-cycle register writes,
//   only while no frame is in flight.
// Timing: the beat stage updates the beat state and reads the sine table
//   register when a frame is accepted; the mix stage then scales, mixes and
//   fills the result register and raises mix_valid. One frame is accepted
//   every cycle while frame_stall is low.
// Reset: configuration returns to its defaults, beat state clears (the first
//   frame starts a beat), the pipeline empties.
// Stall: while mix_stall holds a result, the frame in the mix stage waits and
//   frame_stall rises only when that stage is occupied too.
// ----------------------------------------------------------------------------
module metronome_click_mixer_top
    import mcm_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wen,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     frame_valid,
    output logic                     frame_stall,
    input  frame_t                   frame,
    output logic                     mix_valid,
    input  logic                     mix_stall,
    output mix_t                     mix
);

    logic                      take;
    logic                      busy;
    logic [SINE_ADDR_BITS-1:0] rom_addr;
    logic [ROM_BITS-1:0]       rom_data;
    logic [VOL_BITS-1:0]       volume;
    mcm_item_t                 item;

    // hold the upstream only when the mix stage cannot move
    assign frame_stall = busy;
    assign take        = frame_valid && !busy;

    // beat state updates on every accepted frame; phase advances while a click is active
    mcm_beat #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_beat (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .frame     (frame),
        .rom_addr  (rom_addr),
        .volume    (volume),
        .item      (item)
    );

    // table read lands alongside the registered frame
    mcm_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .clk   (clk),
        .rd_en (take),
        .addr  (rom_addr),
        .data  (rom_data)
    );

    // scale, mix, saturate, drive the result register
    mcm_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .rom_data  (rom_data),
        .volume    (volume),
        .mix_stall (mix_stall),
        .busy      (busy),
        .mix_valid (mix_valid),
        .mix       (mix)
    );

endmodule
